FILE: rtl/md5_message_digest_defines.svh
// Assertion macros used by the MD5 digest RTL.
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MD5_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that an expression never holds outside reset.
`define MD5_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

FILE: rtl/md5_pkg.sv
// Types, command codes and round constants for the MD5 digest block.
package md5_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LENGTH,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } md5_state_e;

  typedef enum logic [1:0] {
    PH_ABSORB,
    PH_EXTRA,
    PH_FINAL
  } md5_phase_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ABSORB,
    OP_PAD,
    OP_LENGTH,
    OP_ROUND,
    OP_FOLD,
    OP_RESTART
  } md5_op_e;

  typedef struct packed {
    md5_op_e    op;
    logic       clear;
    logic [5:0] rnd;
    logic [1:0] word_idx;
  } md5_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic pad_long;
  } md5_stat_t;

  localparam logic       OPER_ABSORB = 1'b0;
  localparam logic       OPER_FINISH = 1'b1;
  localparam logic [5:0] LAST_ROUND  = 6'd63;
  localparam logic [1:0] LAST_WORD   = 2'd3;
  localparam logic [7:0] PAD_BYTE    = 8'h80;

  localparam logic [31:0] CHAIN_INIT [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TAB [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

endpackage

FILE: rtl/md5_dp.sv
// MD5 datapath: block buffer, counters, round unit and chaining words.
module md5_dp import md5_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  md5_cmd_t    cmd_i,
  input  logic [7:0]  data_byte_i,
  output md5_stat_t   stat_o,
  output logic [31:0] digest_word_o
);

  logic [31:0] buf_q   [16];
  logic [31:0] buf_d   [16];
  logic [31:0] chain_q [4];
  logic [31:0] chain_d [4];
  logic [31:0] work_q  [4];
  logic [31:0] work_d  [4];
  logic [5:0]  fill_q, fill_d;
  logic [60:0] cnt_q, cnt_d;

  logic [31:0] a, b, c, d, f, m, sum, rot;
  logic [63:0] rot_wide;
  logic [63:0] bit_len;
  logic [3:0]  widx;
  logic [3:0]  k;
  logic [1:0]  grp;

  assign grp     = cmd_i.rnd[5:4];
  assign k       = cmd_i.rnd[3:0];
  assign bit_len = {cnt_q, 3'b000};

  always_comb begin
    if (cmd_i.rnd == 6'd0) begin
      a = chain_q[0];
      b = chain_q[1];
      c = chain_q[2];
      d = chain_q[3];
    end else begin
      a = work_q[0];
      b = work_q[1];
      c = work_q[2];
      d = work_q[3];
    end
    case (grp)
      2'd0: begin
        f    = d ^ (b & (c ^ d));
        widx = k;
      end
      2'd1: begin
        f    = c ^ (d & (b ^ c));
        widx = 4'(k * 4'd5 + 4'd1);
      end
      2'd2: begin
        f    = b ^ c ^ d;
        widx = 4'(k * 4'd3 + 4'd5);
      end
      default: begin
        f    = c ^ (b | ~d);
        widx = 4'(k * 4'd7);
      end
    endcase
    m        = buf_q[widx];
    sum      = a + f + ROUND_K[cmd_i.rnd] + m;
    rot_wide = {sum, sum} << ROT_TAB[{grp, k[1:0]}];
    rot      = rot_wide[63:32];
  end

  always_comb begin
    buf_d = buf_q;
    case (cmd_i.op)
      OP_ABSORB: begin
        buf_d[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] = data_byte_i;
      end
      OP_PAD: begin
        for (int j = 0; j < 16; j++) begin
          for (int bt = 0; bt < 4; bt++) begin
            if ({4'(j), 2'(bt)} == fill_q) begin
              buf_d[j][bt*8 +: 8] = PAD_BYTE;
            end else if ({4'(j), 2'(bt)} > fill_q) begin
              buf_d[j][bt*8 +: 8] = 8'h00;
            end
          end
        end
      end
      OP_LENGTH: begin
        if (cmd_i.clear) begin
          for (int j = 0; j < 14; j++) begin
            buf_d[j] = 32'h0;
          end
        end
        buf_d[14] = bit_len[31:0];
        buf_d[15] = bit_len[63:32];
      end
      default: ;
    endcase
  end

  always_comb begin
    chain_d = chain_q;
    work_d  = work_q;
    fill_d  = fill_q;
    cnt_d   = cnt_q;
    case (cmd_i.op)
      OP_ABSORB: begin
        fill_d = fill_q + 6'd1;
        cnt_d  = cnt_q + 61'd1;
      end
      OP_ROUND: begin
        work_d[0] = d;
        work_d[1] = b + rot;
        work_d[2] = b;
        work_d[3] = c;
      end
      OP_FOLD: begin
        for (int i = 0; i < 4; i++) begin
          chain_d[i] = chain_q[i] + work_q[i];
        end
      end
      OP_RESTART: begin
        chain_d = CHAIN_INIT;
        fill_d  = 6'd0;
        cnt_d   = 61'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= CHAIN_INIT;
      fill_q  <= 6'd0;
      cnt_q   <= 61'd0;
    end else begin
      chain_q <= chain_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    work_q <= work_d;
  end

  assign stat_o.fill_last = (fill_q == 6'd63);
  assign stat_o.pad_long  = (fill_q[5:3] == 3'b111);
  assign digest_word_o    = chain_q[cmd_i.word_idx];

endmodule

FILE: rtl/md5_ctrl.sv
// MD5 controller: sequences absorb, padding, rounds and digest output.
module md5_ctrl import md5_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       operation_i,
  input  logic       out_ready_i,
  input  md5_stat_t  stat_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  output logic [1:0] word_index_o,
  output logic       last_word_o,
  output md5_cmd_t   cmd_o
);

  md5_state_e state_q, state_d;
  md5_phase_e phase_q, phase_d;
  logic [5:0] rnd_q, rnd_d;
  logic [1:0] idx_q, idx_d;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (operation_i == OPER_FINISH) begin
            state_d = ST_PAD;
          end else if (stat_i.fill_last) begin
            state_d = ST_ROUND;
            phase_d = PH_ABSORB;
            rnd_d   = 6'd0;
          end
        end
      end
      ST_PAD: begin
        rnd_d = 6'd0;
        if (stat_i.pad_long) begin
          state_d = ST_ROUND;
          phase_d = PH_EXTRA;
        end else begin
          state_d = ST_LENGTH;
        end
      end
      ST_LENGTH: begin
        state_d = ST_ROUND;
        phase_d = PH_FINAL;
        rnd_d   = 6'd0;
      end
      ST_ROUND: begin
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == LAST_ROUND) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        case (phase_q)
          PH_EXTRA: state_d = ST_LENGTH;
          PH_FINAL: begin
            state_d = ST_EMIT;
            idx_d   = 2'd0;
          end
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          idx_d = idx_q + 2'd1;
          if (idx_q == LAST_WORD) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o         = 1'b0;
    out_valid_o        = 1'b0;
    cmd_o.op           = OP_NONE;
    cmd_o.clear        = 1'b0;
    cmd_o.rnd          = rnd_q;
    cmd_o.word_idx     = idx_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && operation_i == OPER_ABSORB) begin
          cmd_o.op = OP_ABSORB;
        end
      end
      ST_PAD:   cmd_o.op = OP_PAD;
      ST_LENGTH: begin
        cmd_o.op    = OP_LENGTH;
        cmd_o.clear = (phase_q == PH_EXTRA);
      end
      ST_ROUND: cmd_o.op = OP_ROUND;
      ST_FOLD:  cmd_o.op = OP_FOLD;
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i && idx_q == LAST_WORD) begin
          cmd_o.op = OP_RESTART;
        end
      end
      default: ;
    endcase
  end

  assign word_index_o = idx_q;
  assign last_word_o  = (idx_q == LAST_WORD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_ABSORB;
      rnd_q   <= 6'd0;
      idx_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
    end
  end

endmodule

FILE: rtl/md5_message_digest.sv
// MD5 message digest over a byte stream, one round per cycle.
// Absorb: each byte goes into the block buffer; a full block then runs 64 rounds and a fold.
// Finish: pad, length, 64 rounds and a fold, with an extra 64 rounds and fold before the length
// when the pad byte leaves fewer than 8 bytes free, then four digest words, one per cycle as taken.
// One item at a time; the shared round unit sets the rate.
// Reset loads the initial chaining words and clears the byte counts.
`include "md5_message_digest_defines.svh"
module md5_message_digest import md5_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        last_word_o
);

  md5_cmd_t  cmd;
  md5_stat_t stat;
  logic      in_fire, out_fire, busy;

  md5_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .word_index_o(word_index_o),
    .last_word_o (last_word_o),
    .cmd_o       (cmd)
  );

  md5_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .data_byte_i  (data_byte_i),
    .stat_o       (stat),
    .digest_word_o(digest_word_o)
  );

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign busy     = !in_ready_o && !out_valid_o;

  `MD5_ASSERT_NEVER(a_no_overlap, in_ready_o && out_valid_o, "input and output both open")
  `MD5_ASSERT(a_finish_busy, in_fire && operation_i |=> busy, "finish item not started")
  `MD5_ASSERT(a_last_idle, out_fire && last_word_o |=> in_ready_o, "not idle after last word")
  `MD5_ASSERT_NEVER(a_round_no_input, cmd.op == OP_ROUND && in_ready_o, "input taken in rounds")

endmodule
